>>> src/eikfs_pkg.sv
// shared types and constants of the fast sweeping eikonal solver
`default_nettype none
package eikfs_pkg;

	// default grid bounds
	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS_DEF    = 256;

	// field and register widths
	localparam int TIME_W     = 31;
	localparam int SLOW_W     = 24;
	localparam int SPACING_W  = 24;
	localparam int MAXT_W     = 30;
	localparam int THR_W      = 20;
	localparam int DIM_W      = 9;
	localparam int ROUNDS_W   = 16;
	localparam int SUM_W      = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 30;

	localparam logic [ROUNDS_W-1:0] ROUND_CAP = 16'hFFFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SPACING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONV_THRESH  = 3'd4;

	// item opcodes
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_RUN  = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [7:0]        column;
		logic [7:0]        row;
		logic [SLOW_W-1:0] slowness;
		logic              is_source;
	} cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0]   travel_time;
		logic [ROUNDS_W-1:0] rounds_done;
		logic                converged;
	} res_t;

endpackage
`default_nettype wire

>>> src/eikfs_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module eikfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> src/eikonal_fast_sweep_solver.sv
// top level of the fast sweeping eikonal solver
// Solves the 2D eikonal equation by Godunov fast sweeping over a grid held in two
// synchronous RAMs (slowness and travel time, MAX_ROWS x 2^clog2(MAX_COLUMNS) each).
// A run item visits cells one at a time through the single read port of the time RAM:
// each cell takes 5 reads, 3 arithmetic steps and 1 write-back when the one-sided
// update applies, and the two-sided update also passes through the 32-step square
// root unit.
// Each round of a run makes 4*rows*columns cell visits.
// The stores have no clearing pass; cells must be loaded before they are read or swept.
`default_nettype none
module eikonal_fast_sweep_solver
	import eikfs_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire cmd_t                  item,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output res_t                       result
);

	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int AW     = COL_W + ROW_W;
	localparam int DEPTH  = MAX_ROWS * (2 ** COL_W);
	localparam int DC_W   = $clog2(MAX_COLUMNS + 1);
	localparam int DR_W   = $clog2(MAX_ROWS + 1);
	localparam int PROD_W = DC_W + DR_W;
	localparam int LIM_W  = THR_W + PROD_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_WAIT, ST_RUN_DIM, ST_RUN_LIM, ST_CELL_RD, ST_MUL_A, ST_MUL_B,
		ST_MUL_C, ST_SQ_PREP, ST_SQRT, ST_UPD, ST_ROUND_END, ST_FINISH
	} state_t;

	// configuration registers
	logic [DIM_W-1:0]     grid_columns_q, grid_rows_q;
	logic [SPACING_W-1:0] cell_spacing_q;
	logic [MAXT_W-1:0]    max_time_q;
	logic [THR_W-1:0]     threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= 9'd256;
			grid_rows_q    <= 9'd256;
			cell_spacing_q <= 24'd2560;
			max_time_q     <= 30'd10485760;
			threshold_q    <= 20'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_COLUMNS: grid_columns_q <= cfg_wdata[DIM_W-1:0];
				REG_GRID_ROWS:    grid_rows_q    <= cfg_wdata[DIM_W-1:0];
				REG_CELL_SPACING: cell_spacing_q <= cfg_wdata[SPACING_W-1:0];
				REG_MAX_TIME:     max_time_q     <= cfg_wdata[MAXT_W-1:0];
				REG_CONV_THRESH:  threshold_q    <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	state_t                state_q;
	logic                  result_valid_q;
	res_t                  result_q;
	logic                  rd_ok_q;
	logic [DC_W-1:0]       cols_q, ci_q;
	logic [DR_W-1:0]       rows_q, ri_q;
	logic [PROD_W-1:0]     cells_q;
	logic [LIM_W-1:0]      limit_q;
	logic [SUM_W-1:0]      sum_q;
	logic [ROUNDS_W-1:0]   rounds_q;
	logic                  conv_q;
	logic [1:0]            sweep_q;
	logic [2:0]            rk_q;
	logic [TIME_W-1:0]     old_q, tl_q, tr_q, tu_q, td_q, a_q, b_q, d_q;
	logic [SLOW_W-1:0]     slow_q;
	logic [47:0]           fprod_q;
	logic [31:0]           f_q;
	logic [63:0]           ff_q, sq_v_q, sq_r_q, sq_bit_q;
	logic [61:0]           dd_q;
	logic                  skip_q;
	logic [4:0]            sq_cnt_q;

	// ram ports
	logic              t_we, s_we;
	logic [AW-1:0]     t_waddr, t_raddr, s_raddr;
	logic [TIME_W-1:0] t_wdata, t_rdata;
	logic [SLOW_W-1:0] s_rdata;

	eikfs_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_time_ram (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	eikfs_ram #(.WIDTH(SLOW_W), .DEPTH(DEPTH)) u_slow_ram (
		.clk(clk), .we(s_we), .waddr(t_waddr), .wdata(item.slowness),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	// handshake
	logic accept, in_range;
	logic [AW-1:0] item_addr;
	assign item_ready = (state_q == ST_IDLE) && (!result_valid_q || result_ready);
	assign accept     = item_valid && item_ready;
	assign in_range   = (32'(item.column) < 32'(MAX_COLUMNS)) && (32'(item.row) < 32'(MAX_ROWS));
	assign item_addr  = {ROW_W'(item.row), COL_W'(item.column)};
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a new result is registered this cycle
	logic result_set;
	assign result_set = ((state_q == ST_IDLE) && accept && (item.opcode != OP_READ)
	                     && (item.opcode != OP_RUN))
	                  || (state_q == ST_RD_WAIT)
	                  || ((state_q == ST_FINISH) && (!result_valid_q || result_ready));

	// cell position and neighbors for the current sweep direction
	logic            col_down, row_down;
	logic [DC_W-1:0] c_cur, c_l, c_r;
	logic [DR_W-1:0] r_cur, r_u, r_d;
	logic [AW-1:0]   addr_c;
	assign col_down = (sweep_q == 2'd1) || (sweep_q == 2'd2);
	assign row_down = sweep_q[1];
	assign c_cur = col_down ? (cols_q - DC_W'(1) - ci_q) : ci_q;
	assign r_cur = row_down ? (rows_q - DR_W'(1) - ri_q) : ri_q;
	assign c_l   = (c_cur == '0) ? c_cur : c_cur - DC_W'(1);
	assign c_r   = ((c_cur + DC_W'(1)) < cols_q) ? c_cur + DC_W'(1) : c_cur;
	assign r_u   = (r_cur == '0) ? r_cur : r_cur - DR_W'(1);
	assign r_d   = ((r_cur + DR_W'(1)) < rows_q) ? r_cur + DR_W'(1) : r_cur;
	assign addr_c = {r_cur[ROW_W-1:0], c_cur[COL_W-1:0]};

	// read address selection
	always_comb begin
		if (state_q == ST_IDLE) begin
			t_raddr = item_addr;
			s_raddr = item_addr;
		end else begin
			s_raddr = addr_c;
			case (rk_q)
				3'd1:    t_raddr = {r_cur[ROW_W-1:0], c_l[COL_W-1:0]};
				3'd2:    t_raddr = {r_cur[ROW_W-1:0], c_r[COL_W-1:0]};
				3'd3:    t_raddr = {r_u[ROW_W-1:0], c_cur[COL_W-1:0]};
				3'd4:    t_raddr = {r_d[ROW_W-1:0], c_cur[COL_W-1:0]};
				default: t_raddr = addr_c;
			endcase
		end
	end

	// cell update result
	logic [TIME_W-1:0] min_ab, diff;
	logic [33:0]       t_new;
	logic              t_less;
	logic [SUM_W:0]    sum_add;
	logic [SUM_W-1:0]  sum_next;
	assign min_ab = (a_q < b_q) ? a_q : b_q;
	assign t_new  = skip_q ? (34'(min_ab) + 34'(f_q))
	                       : ((34'(a_q) + 34'(b_q) + 34'(sq_r_q[32:0])) >> 1);
	assign t_less   = t_new < 34'(old_q);
	assign diff     = old_q - t_new[TIME_W-1:0];
	assign sum_add  = (SUM_W+1)'(sum_q) + (SUM_W+1)'(diff);
	assign sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

	// writes
	assign s_we    = accept && (item.opcode == OP_LOAD) && in_range;
	assign t_we    = s_we || ((state_q == ST_UPD) && t_less);
	assign t_waddr = (state_q == ST_UPD) ? addr_c : item_addr;
	assign t_wdata = (state_q == ST_UPD) ? t_new[TIME_W-1:0]
	               : (item.is_source ? '0 : {max_time_q, 1'b0});

	// grid size clamp and start test
	logic [DC_W-1:0] cols_clamp;
	logic [DR_W-1:0] rows_clamp;
	logic            pre_hit;
	always_comb begin
		if (grid_columns_q < 9'd2) cols_clamp = DC_W'(2);
		else if (32'(grid_columns_q) > 32'(MAX_COLUMNS)) cols_clamp = DC_W'(MAX_COLUMNS);
		else cols_clamp = DC_W'(grid_columns_q);
		if (grid_rows_q < 9'd2) rows_clamp = DR_W'(2);
		else if (32'(grid_rows_q) > 32'(MAX_ROWS)) rows_clamp = DR_W'(MAX_ROWS);
		else rows_clamp = DR_W'(grid_rows_q);
	end
	assign pre_hit = (34'({max_time_q, 3'b000}) + 34'({max_time_q, 1'b0})) < 34'(threshold_q);

	// multiply and square root step helpers
	logic [48:0] f_round;
	logic [63:0] sq_rb;
	logic [ROUNDS_W-1:0] rounds_inc;
	assign f_round    = (49'(fprod_q) + 49'd2048) >> 12;
	assign sq_rb      = sq_r_q + sq_bit_q;
	assign rounds_inc = rounds_q + ROUNDS_W'(1);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			rk_q           <= '0;
			sweep_q        <= '0;
			ci_q           <= '0;
			ri_q           <= '0;
			sum_q          <= '0;
			rounds_q       <= '0;
			conv_q         <= 1'b0;
		end else begin
			if (result_valid_q && result_ready && !result_set) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.opcode)
							OP_READ: begin
								rd_ok_q <= in_range;
								state_q <= ST_RD_WAIT;
							end
							OP_RUN: begin
								rounds_q <= '0;
								conv_q   <= 1'b0;
								state_q  <= ST_RUN_DIM;
							end
							default: begin
								result_q       <= '0;
								result_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_RD_WAIT: begin
					result_q.travel_time <= rd_ok_q ? t_rdata : '0;
					result_q.rounds_done <= '0;
					result_q.converged   <= 1'b0;
					result_valid_q       <= 1'b1;
					state_q              <= ST_IDLE;
				end
				ST_RUN_DIM: begin
					cols_q  <= cols_clamp;
					rows_q  <= rows_clamp;
					cells_q <= PROD_W'(cols_clamp) * PROD_W'(rows_clamp);
					if (pre_hit) begin
						conv_q  <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_RUN_LIM;
					end
				end
				ST_RUN_LIM: begin
					limit_q <= LIM_W'(threshold_q) * LIM_W'(cells_q);
					sum_q   <= '0;
					ci_q    <= '0;
					ri_q    <= '0;
					sweep_q <= '0;
					rk_q    <= '0;
					state_q <= ST_CELL_RD;
				end
				// five time reads, one per cycle, data arriving in the cycle after each read
				ST_CELL_RD: begin
					rk_q <= rk_q + 3'd1;
					case (rk_q)
						3'd1: begin
							old_q  <= t_rdata;
							slow_q <= s_rdata;
						end
						3'd2: tl_q <= t_rdata;
						3'd3: tr_q <= t_rdata;
						3'd4: tu_q <= t_rdata;
						3'd5: begin
							td_q    <= t_rdata;
							state_q <= ST_MUL_A;
						end
						default: ;
					endcase
				end
				ST_MUL_A: begin
					a_q     <= (tl_q < tr_q) ? tl_q : tr_q;
					b_q     <= (tu_q < td_q) ? tu_q : td_q;
					fprod_q <= 48'(slow_q) * 48'(cell_spacing_q);
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					f_q     <= (f_round > 49'h8000_0000) ? 32'h8000_0000 : f_round[31:0];
					d_q     <= (a_q > b_q) ? a_q - b_q : b_q - a_q;
					state_q <= ST_MUL_C;
				end
				ST_MUL_C: begin
					ff_q    <= 64'(f_q) * 64'(f_q);
					dd_q    <= 62'(d_q) * 62'(d_q);
					skip_q  <= 32'(d_q) >= f_q;
					state_q <= (32'(d_q) >= f_q) ? ST_UPD : ST_SQ_PREP;
				end
				ST_SQ_PREP: begin
					sq_v_q   <= (ff_q << 1) - 64'(dd_q);
					sq_r_q   <= '0;
					sq_bit_q <= 64'h4000_0000_0000_0000;
					sq_cnt_q <= '0;
					state_q  <= ST_SQRT;
				end
				// floor square root, one result bit per cycle
				ST_SQRT: begin
					if (sq_v_q >= sq_rb) begin
						sq_v_q <= sq_v_q - sq_rb;
						sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
					sq_cnt_q <= sq_cnt_q + 5'd1;
					if (sq_cnt_q == 5'd31) begin
						state_q <= ST_UPD;
					end
				end
				// write back and step to the next cell
				ST_UPD: begin
					if (t_less) begin
						sum_q <= sum_next;
					end
					rk_q    <= '0;
					state_q <= ST_CELL_RD;
					if (ri_q == rows_q - DR_W'(1)) begin
						ri_q <= '0;
						if (ci_q == cols_q - DC_W'(1)) begin
							ci_q    <= '0;
							sweep_q <= sweep_q + 2'd1;
							if (sweep_q == 2'd3) begin
								state_q <= ST_ROUND_END;
							end
						end else begin
							ci_q <= ci_q + DC_W'(1);
						end
					end else begin
						ri_q <= ri_q + DR_W'(1);
					end
				end
				ST_ROUND_END: begin
					rounds_q <= rounds_inc;
					if (64'(sum_q) < 64'(limit_q)) begin
						conv_q  <= 1'b1;
						state_q <= ST_FINISH;
					end else if ((sum_q == '0) || (rounds_inc == ROUND_CAP)) begin
						state_q <= ST_FINISH;
					end else begin
						sum_q   <= '0;
						rk_q    <= '0;
						state_q <= ST_CELL_RD;
					end
				end
				ST_FINISH: begin
					if (!result_valid_q || result_ready) begin
						result_q.travel_time <= '0;
						result_q.rounds_done <= rounds_q;
						result_q.converged   <= conv_q;
						result_valid_q       <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// time ram is written only by a load transfer or a cell update
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		t_we |-> (state_q == ST_UPD) || (accept && (state_q == ST_IDLE)))
		else $error("time ram written outside load or update");

	// root step keeps exactly one bit in the trial mask
	a_sqrt_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> $onehot(sq_bit_q))
		else $error("square root mask lost its bit");

	// arithmetic starts only after all five reads of the cell and its neighbors
	a_reads_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_A) |-> ($past(state_q) == ST_CELL_RD) && ($past(rk_q) == 3'd5))
		else $error("cell arithmetic began before reads completed");

endmodule
`default_nettype wire
